[hw/rtl/sm3_pkg.sv]
// ----------------------------------------------------------------------------
// SM3 package
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam int WORD_W = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] TJ_LOW = 32'h79cc4519;
    localparam logic [31:0] TJ_HIGH = 32'h7a879d8a;
    localparam logic [31:0] PAD_WORD = 32'h80000000;

    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } item_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

[hw/rtl/sm3_if.sv]
// ----------------------------------------------------------------------------
// SM3 stream interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
interface sm3_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        final_word;
    modport source (output valid, message_word, byte_count, final_word, input ready);
    modport sink (input valid, message_word, byte_count, final_word, output ready);
endinterface

interface sm3_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
    modport source (output valid, digest_word, digest_index, digest_last, input ready);
    modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

[hw/rtl/sm3_queue.sv]
// ----------------------------------------------------------------------------
// SM3 item queue
// Short FIFO that parts the input front from the compression back end.
// ----------------------------------------------------------------------------
module sm3_queue #(
    parameter int DEPTH = sm3_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sm3_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output sm3_pkg::item_t pop_item,
    output logic           empty
);
    import sm3_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0] cnt_reg;

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign pop_item = mem[rd_reg];

    always_ff @(posedge clk) begin
        if (push && !full) begin
            mem[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else begin
            if (push && !full) begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> full) else $error("full dropped without pop");
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        empty && !push |=> empty) else $error("empty left without push");

endmodule

[hw/rtl/sm3_core.sv]
// ----------------------------------------------------------------------------
// SM3 compression back end
// Pads the message, buffers blocks, runs one round per cycle, emits digest.
// ----------------------------------------------------------------------------
module sm3_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  sm3_pkg::item_t item,
    output logic           item_pop,
    sm3_dig_if.source      dig
);
    import sm3_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_EXP   = 6'b000100,
        S_ROUND = 6'b001000,
        S_FOLD  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] cv_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [3:0]  wib_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;
    logic [1:0]  pad_reg;
    logic [2:0]  oidx_reg;

    logic [2:0]  cnt_eff;
    logic [31:0] pad_word;
    logic        push_en;
    logic [31:0] push_w;
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wexp;

    always_comb begin
        cnt_eff = (item.count > 3'd4 || !item.last) ? 3'd4 : item.count;
        case (cnt_eff)
            3'd0: pad_word = 32'h80000000;
            3'd1: pad_word = {item.word[31:24], 24'h800000};
            3'd2: pad_word = {item.word[31:16], 16'h8000};
            3'd3: pad_word = {item.word[31:8], 8'h80};
            default: pad_word = item.word;
        endcase
    end

    always_comb begin
        tj = (rnd_reg < 6'd16) ? TJ_LOW : TJ_HIGH;
        a12 = rotl(v_reg[0], 5'd12);
        ss1 = rotl(a12 + v_reg[4] + rotl(tj, rnd_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16) begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end
        else begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + v_reg[7] + ss1 + w_reg[0];
        wexp = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15))
             ^ rotl(w_reg[3], 5'd7) ^ w_reg[10];
    end

    // Word source of the buffer: input items in IDLE, padding words in PAD.
    always_comb begin
        push_en = 1'b0;
        push_w = '0;
        item_pop = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    item_pop = 1'b1;
                    push_en = 1'b1;
                    push_w = pad_word;
                    if (wib_reg == 4'd15) begin
                        state_next = S_EXP;
                    end
                    else if (item.last) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD: begin
                push_en = 1'b1;
                if (pad_reg == 2'd1) begin
                    push_w = PAD_WORD;
                end
                else if (wib_reg == 4'd14 && pad_reg == 2'd0) begin
                    push_w = len_reg[63:32];
                end
                else if (wib_reg == 4'd15 && pad_reg == 2'd2) begin
                    push_w = len_reg[31:0];
                end
                if (wib_reg == 4'd15) begin
                    state_next = S_EXP;
                end
            end
            S_EXP: state_next = S_ROUND;
            S_ROUND: if (rnd_reg == 6'd63) state_next = S_FOLD;
            S_FOLD: begin
                if (fin_reg && pad_reg == 2'd3) state_next = S_OUT;
                else if (fin_reg) state_next = S_PAD;
                else state_next = S_IDLE;
            end
            S_OUT: if (dig.ready && oidx_reg == 3'd7) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign dig.valid = (state_reg == S_OUT);
    assign dig.digest_word = cv_reg[oidx_reg];
    assign dig.digest_index = oidx_reg;
    assign dig.digest_last = (oidx_reg == 3'd7);

    // pad_reg: 0 zeros/length phase, 1 pending 0x80 word, 2 length high placed,
    // 3 message done.
    always_ff @(posedge clk) begin
        if (push_en) begin
            w_reg[wib_reg] <= push_w;
        end
        else if (state_reg == S_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wexp;
        end
        if (state_reg == S_EXP) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= cv_reg[i];
        end
        else if (state_reg == S_ROUND) begin
            v_reg[0] <= tt1;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= rotl(v_reg[1], 5'd9);
            v_reg[3] <= v_reg[2];
            v_reg[4] <= perm0(tt2);
            v_reg[5] <= v_reg[4];
            v_reg[6] <= rotl(v_reg[5], 5'd19);
            v_reg[7] <= v_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < 8; i++) cv_reg[i] <= SM3_IV[i];
            wib_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            fin_reg <= 1'b0;
            pad_reg <= '0;
            oidx_reg <= '0;
        end
        else begin
            state_reg <= state_next;
            if (push_en) begin
                wib_reg <= wib_reg + 1'b1;
            end
            if (state_reg == S_IDLE && item_valid) begin
                len_reg <= len_reg + {58'd0, cnt_eff, 3'd0};
                if (item.last) begin
                    fin_reg <= 1'b1;
                    pad_reg <= (cnt_eff == 3'd4) ? 2'd1 : 2'd0;
                end
            end
            if (state_reg == S_PAD) begin
                if (pad_reg == 2'd1) pad_reg <= 2'd0;
                else if (wib_reg == 4'd15 && pad_reg == 2'd2) pad_reg <= 2'd3;
                else if (wib_reg == 4'd14 && pad_reg == 2'd0) pad_reg <= 2'd2;
            end
            if (state_reg == S_ROUND) rnd_reg <= rnd_reg + 1'b1;
            if (state_reg == S_FOLD) begin
                for (int i = 0; i < 8; i++) cv_reg[i] <= cv_reg[i] ^ v_reg[i];
            end
            if (state_reg == S_OUT && dig.ready) begin
                oidx_reg <= oidx_reg + 1'b1;
                if (oidx_reg == 3'd7) begin
                    for (int i = 0; i < 8; i++) cv_reg[i] <= SM3_IV[i];
                    wib_reg <= '0;
                    len_reg <= '0;
                    fin_reg <= 1'b0;
                    pad_reg <= '0;
                end
            end
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> state_reg == S_IDLE) else $error("pop outside idle");
    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FOLD |-> rnd_reg == 6'd0) else $error("round count off");
    a_out_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> fin_reg && pad_reg == 2'd3) else $error("early digest");

endmodule

[hw/rtl/sm3_hash_engine.sv]
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streaming SM3 hash: message words in, eight digest words out per message.
// ----------------------------------------------------------------------------
// Message words enter on msg, each with a count of valid leading bytes and a
// flag on the final word. A four-entry queue holds words ahead of the back
// end, which buffers sixteen words a block and runs one compression round per
// cycle. Each block is buffered, loaded into the working registers, run
// through 64 rounds by the single round unit and folded into the chaining
// value. On a final word the back end writes the padding words one a cycle,
// runs one or two more blocks and then offers the eight digest words on dig,
// one per accepted transfer, index 0 first. A stalled receiver holds the
// digest; the queue keeps taking input until it fills. After the last digest
// word the chaining value returns to the initial vector. Reset clears the
// queue and loads the initial vector at once.
// ----------------------------------------------------------------------------
module sm3_hash_engine #(
    parameter int QUEUE_DEPTH = sm3_pkg::QUEUE_DEPTH
) (
    input logic       clk,
    input logic       rst_n,
    sm3_msg_if.sink   msg,
    sm3_dig_if.source dig
);
    import sm3_pkg::*;

    item_t in_item, q_item;
    logic  q_full, q_empty, q_pop;

    assign in_item = '{word: msg.message_word, count: msg.byte_count, last: msg.final_word};
    assign msg.ready = !q_full;

    sm3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(msg.valid), .push_item(in_item), .full(q_full),
        .pop(q_pop), .pop_item(q_item), .empty(q_empty)
    );

    sm3_core u_core (
        .clk(clk), .rst_n(rst_n),
        .item_valid(!q_empty), .item(q_item), .item_pop(q_pop),
        .dig(dig)
    );

endmodule
